// File: src/wcm_pkg.sv
`default_nettype none

package wcm_pkg;

  localparam int unsigned IN_TDATA_W  = 136;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned MIX_W       = 16;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_START = 2'd1,
    CMD_MIX   = 2'd2
  } wcm_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_REDUCE,
    ST_READ,
    ST_MUL,
    ST_FIN
  } wcm_state_e;

endpackage

`default_nettype wire

// File: src/wavetable_channel_mixer.sv
`default_nettype none

// Channel  Signals              Item
// -------  -------------------  ---------------------------------------------
// in       s_axis_t*  (136/2)   command in tuser, channel..mix_in in tdata
// out      m_axis_t*  (24)      mix_out, channel_active in tdata
//
// An item is taken only in the idle state; ready drops for the whole command.
// Start, unused commands and mixes on stopped or absent channels pass the
// address and finish states, as do writes; running mixes add read and multiply
// states (one multiplier is shared by the volume and the sample scaling, one
// sample memory read port). A memory depth that is not a power of two adds
// address reduction to writes and running mixes. The last step stalls while the
// output register is still full. Reset clears channel state; no clearing pass.
module wavetable_channel_mixer #(
  parameter int NUM_CHANNELS     = 8,
  parameter int SAMPLE_MEM_DEPTH = 65536
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // from bit 0: channel(3) mem_address(16) mem_data(8) sample_length(16)
  // loop_length(16) start_position(24) speed(16) channel_volume(8)
  // envelope_level(7) mix_in(16), zero fill
  input  wire logic [wcm_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // from bit 0: command(2)
  input  wire logic [wcm_pkg::IN_TUSER_W-1:0]     s_axis_tuser_i,
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // from bit 0: mix_out(16) channel_active(1), zero fill
  output logic [wcm_pkg::OUT_TDATA_W-1:0]         m_axis_tdata_o
);

  import wcm_pkg::*;

  localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int IDX_W = (CH_W > 3) ? CH_W : 3;
  localparam int AW    = $clog2(SAMPLE_MEM_DEPTH);
  localparam bit IS_POW2 = ((SAMPLE_MEM_DEPTH & (SAMPLE_MEM_DEPTH - 1)) == 0);
  localparam logic [23:0] DEPTH_W = 24'(SAMPLE_MEM_DEPTH);

  wcm_state_e state_q, state_d;

  // captured item
  wcm_cmd_e     cmd_q;
  logic [2:0]   ch_q;
  logic [15:0]  addr_q;
  logic [7:0]   data_q;
  logic [15:0]  slen_q;
  logic [15:0]  llen_q;
  logic [23:0]  spos_q;
  logic [15:0]  spd_in_q;
  logic [7:0]   cvol_q;
  logic [6:0]   env_q;
  logic [15:0]  mix_in_q;

  // channel state
  logic [23:0] pos_q [NUM_CHANNELS];
  logic [15:0] spd_q [NUM_CHANNELS];

  logic [7:0]  mem [SAMPLE_MEM_DEPTH];
  logic [7:0]  rd_q;

  logic [15:0] rem_q;
  logic [2:0]  step_q;
  logic        mix_go_q;
  logic [7:0]  vol_q;
  logic [9:0]  term_q;
  logic [15:0] adv_ipos_q;
  logic [7:0]  adv_frac_q;

  logic [15:0] mix_out_q;
  logic        active_q;
  logic        out_valid_q;

  logic             s_fire;
  logic             fin_fire;
  logic             mem_we;
  logic             ch_valid;
  logic [IDX_W-1:0] ch_ext;
  logic [CH_W-1:0]  ch_idx;
  logic [23:0]      pos_cur;
  logic [15:0]      spd_cur;
  logic             mix_go;
  logic [23:0]      red_lim;
  logic             red_sub;
  logic [8:0]       mul_a;
  logic [8:0]       mul_b;
  logic [17:0]      prod;
  logic [8:0]       frac_sum;
  logic             wrap;
  logic [15:0]      new_ipos;
  logic [15:0]      new_spd;
  logic [15:0]      mix_sum;

  assign ch_ext   = IDX_W'(ch_q);
  assign ch_idx   = ch_ext[CH_W-1:0];
  assign ch_valid = 32'(ch_q) < 32'(NUM_CHANNELS);
  assign pos_cur  = pos_q[ch_idx];
  assign spd_cur  = spd_q[ch_idx];
  assign mix_go   = (cmd_q == CMD_MIX) && ch_valid && (spd_cur != 16'd0);

  // address reduction: compare-subtract against depth << step
  assign red_lim = DEPTH_W << step_q;
  assign red_sub = {8'd0, rem_q} >= red_lim;

  // shared multiplier: volume in ST_ADDR, sample times volume in ST_MUL
  assign mul_a = (state_q == ST_MUL) ? {rd_q[7], rd_q} : {1'b0, cvol_q};
  assign mul_b = (state_q == ST_MUL) ? {1'b0, vol_q} : {2'b00, env_q};
  assign prod  = 18'($signed(mul_a) * $signed(mul_b));

  assign frac_sum = {1'b0, pos_cur[7:0]} + {1'b0, spd_cur[7:0]};

  assign wrap     = adv_ipos_q >= slen_q;
  assign new_ipos = wrap ? (adv_ipos_q - llen_q) : adv_ipos_q;
  assign mix_sum  = mix_in_q + {{6{term_q[9]}}, term_q};

  always_comb begin
    new_spd = spd_cur;
    if (cmd_q == CMD_START) begin
      new_spd = spd_in_q;
    end else if (mix_go_q && wrap && (llen_q == 16'd0)) begin
      new_spd = 16'd0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) state_d = ST_ADDR;
      end
      ST_ADDR: begin
        if (cmd_q == CMD_WRITE) begin
          state_d = IS_POW2 ? ST_FIN : ST_REDUCE;
        end else if (mix_go) begin
          state_d = IS_POW2 ? ST_READ : ST_REDUCE;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_REDUCE: begin
        if (step_q == 3'd0) state_d = mix_go_q ? ST_READ : ST_FIN;
      end
      ST_READ: state_d = ST_MUL;
      ST_MUL:  state_d = ST_FIN;
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    fin_fire        = 1'b0;
    mem_we          = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready_o = 1'b1;
      ST_FIN: begin
        fin_fire = !out_valid_q || m_axis_tready_i;
        mem_we   = fin_fire && (cmd_q == CMD_WRITE);
      end
      default: ;
    endcase
  end

  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      cmd_q    <= wcm_cmd_e'(s_axis_tuser_i);
      ch_q     <= s_axis_tdata_i[2:0];
      addr_q   <= s_axis_tdata_i[18:3];
      data_q   <= s_axis_tdata_i[26:19];
      slen_q   <= s_axis_tdata_i[42:27];
      llen_q   <= s_axis_tdata_i[58:43];
      spos_q   <= s_axis_tdata_i[82:59];
      spd_in_q <= s_axis_tdata_i[98:83];
      cvol_q   <= s_axis_tdata_i[106:99];
      env_q    <= s_axis_tdata_i[113:107];
      mix_in_q <= s_axis_tdata_i[129:114];
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_ADDR: begin
        rem_q    <= (cmd_q == CMD_WRITE) ? addr_q : (addr_q + pos_cur[23:8]);
        step_q   <= 3'd7;
        mix_go_q <= mix_go;
        vol_q    <= prod[15:8];
      end
      ST_REDUCE: begin
        if (red_sub) rem_q <= rem_q - red_lim[15:0];
        step_q <= step_q - 3'd1;
      end
      ST_READ: begin
        adv_frac_q <= frac_sum[7:0];
        adv_ipos_q <= pos_cur[23:8] + {8'd0, spd_cur[15:8]} + {15'd0, frac_sum[8]};
      end
      ST_MUL: begin
        term_q <= prod[17:8];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[rem_q[AW-1:0]] <= data_q;
    if (state_q == ST_READ) rd_q <= mem[rem_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        pos_q[i] <= 24'd0;
        spd_q[i] <= 16'd0;
      end
    end else if (fin_fire && ch_valid) begin
      if (cmd_q == CMD_START) begin
        pos_q[ch_idx] <= spos_q;
        spd_q[ch_idx] <= spd_in_q;
      end else if (mix_go_q) begin
        pos_q[ch_idx] <= {new_ipos, adv_frac_q};
        spd_q[ch_idx] <= new_spd;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      mix_out_q <= mix_go_q ? mix_sum : mix_in_q;
      active_q  <= ch_valid && (new_spd != 16'd0);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, active_q, mix_out_q};

endmodule

`default_nettype wire

// File: src/wcm_checker.sv
`default_nettype none

module wcm_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               s_axis_tvalid_i,
  input wire logic                               s_axis_tready_o,
  input wire logic [wcm_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  input wire logic [wcm_pkg::IN_TUSER_W-1:0]     s_axis_tuser_i,
  input wire logic                               m_axis_tvalid_o,
  input wire logic                               m_axis_tready_i,
  input wire logic [wcm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);

  import wcm_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_q;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  // items taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else begin
      pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output item changed while stalled");

  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o)
    else $error("input taken while previous item in work");

  a_out_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> pend_q != 2'd0)
    else $error("output item without an accepted input item");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two items outstanding");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[OUT_TDATA_W-1:17] == '0)
    else $error("output fill bits not zero");

endmodule

bind wavetable_channel_mixer wcm_checker u_wcm_checker (.*);

`default_nettype wire
